// File: design/ax25dp_pkg.sv
// ----------------------------------------------------------------------------
// ax25dp_pkg
// Shared types and constants for the AX.25 digipeater header processor.
// ----------------------------------------------------------------------------
package ax25dp_pkg;

  // Highest digipeater count scanned before the address field counts as
  // unterminated (1..8).
  localparam logic [3:0] MAX_DIGIS = 4'd8;

  localparam int unsigned CALL_W   = 56;
  localparam int unsigned CFG_W    = 56;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // Address field encoding
  localparam logic [7:0] CALL_MASK   = 8'hfe;
  localparam logic [7:0] SSID_MASK   = 8'h1e;
  localparam logic [7:0] REPEAT_BIT  = 8'h80;
  localparam logic [7:0] EXT_BIT     = 8'h01;
  localparam logic [3:0] ADDR_OVERLONG = 4'd15;
  localparam logic [6:0] MIN_FRAME_LEN = 7'd15;
  localparam logic [6:0] POS_SAT       = 7'd127;
  localparam logic [2:0] SSID_POS      = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MY_CALLSIGN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGI_MODE   = 1'd1;

  typedef enum logic [2:0] {
    VERDICT_FORWARD      = 3'd0,
    VERDICT_SHORT        = 3'd1,
    VERDICT_NOT_FOR_ME   = 3'd2,
    VERDICT_DESTINATION  = 3'd3,
    VERDICT_UNTERMINATED = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    verdict_t   verdict;
    logic [3:0] next_hop;
  } result_t;

  typedef struct packed {
    logic [6:0] byte_pos;
    logic [2:0] byte_in_addr;
    logic [3:0] addr_num;
    logic       run_match;
    logic       hdr_done;
    logic       open_found;
    logic       open_is_me;
    logic       hop_after;
    logic [3:0] hop_index;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    byte_pos:     7'd0,
    byte_in_addr: 3'd0,
    addr_num:     4'd0,
    run_match:    1'b1,
    hdr_done:     1'b0,
    open_found:   1'b0,
    open_is_me:   1'b0,
    hop_after:    1'b0,
    hop_index:    4'd0
  };

  // Pipeline control from the top level to the stages
  typedef struct packed {
    logic load_in;   // request taken into the input register
    logic advance;   // input register item moves to the result register
    logic out_take;  // result register drained by the sink
  } pipe_ctl_t;

endpackage

// File: design/ax25_digipeater_header_processor.sv
// ----------------------------------------------------------------------------
// ax25_digipeater_header_processor
// Byte-stream AX.25 address field processor for a digipeater.
// ----------------------------------------------------------------------------
// Frame bytes (CRC excluded) enter on the in_ stream, tlast on the final
// byte, and leave one for one on the out_ stream two register stages later.
// Throughput is one byte per clock: the input register feeds a single pass
// of compare and counter logic into the result register, and both stages
// advance together whenever the result register is empty or being drained.
// In digipeater mode (register 1 = 1) the SSID byte of the first unrepeated
// digipeater address is marked repeated (bit 7 set) when that address equals
// my_callsign (register 0). Callsign bytes compare under 0xfe, the SSID under
// 0x1e, and a zero first byte never matches. On the tlast byte out_tdata
// carries a verdict (forward, too short, not for me, I am the destination,
// unterminated address field) and the next-hop index; on other bytes both
// read zero. Configuration writes take effect at once and belong between
// frames, with the block drained.
// ----------------------------------------------------------------------------
module ax25_digipeater_header_processor
  import ax25dp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,

  // frame byte stream in
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] in_byte
  input  logic                  in_tlast,   // frame_end

  // processed byte stream out
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] out_byte, [10:8] verdict,
                                            // [14:11] next_hop, [15] zero
  output logic                  out_tlast   // out_last
);

  logic [CALL_W-1:0] my_callsign_r;
  logic              digi_mode_r;

  pipe_ctl_t ctl;
  logic      in_valid;
  logic      out_valid;
  item_t     in_item;
  item_t     cur_item;
  result_t   core_res;
  result_t   out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_callsign_r <= '0;
      digi_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MY_CALLSIGN: my_callsign_r <= cfg_wdata[CALL_W-1:0];
        REG_DIGI_MODE:   digi_mode_r   <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Stage handshake: the held request moves on when the result slot frees
  assign ctl.out_take = out_valid & out_tready;
  assign ctl.advance  = in_valid & (~out_valid | out_tready);
  assign in_tready    = ~in_valid | ctl.advance;
  assign ctl.load_in  = in_tvalid & in_tready;

  assign in_item.data = in_tdata[7:0];
  assign in_item.last = in_tlast;

  ax25dp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .item_in  (in_item),
    .valid    (in_valid),
    .item_out (cur_item)
  );

  ax25dp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .item        (cur_item),
    .my_callsign (my_callsign_r),
    .digi_mode   (digi_mode_r),
    .result      (core_res)
  );

  ax25dp_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .res_in  (core_res),
    .valid   (out_valid),
    .res_out (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tlast  = out_res.last;
  assign out_tdata  = {1'b0, out_res.next_hop, out_res.verdict, out_res.data};

endmodule

// File: design/ax25dp_in_reg.sv
// ----------------------------------------------------------------------------
// ax25dp_in_reg
// Input register stage: holds one accepted request until it is processed.
// ----------------------------------------------------------------------------
module ax25dp_in_reg
  import ax25dp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  item_t     item_in,
  output logic      valid,
  output item_t     item_out
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign valid_nxt = ctl.load_in | (valid_r & ~ctl.advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule

// File: design/ax25dp_core.sv
// ----------------------------------------------------------------------------
// ax25dp_core
// Address field parser: per-byte compare, counters and end-of-frame verdict.
// ----------------------------------------------------------------------------
module ax25dp_core
  import ax25dp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  item_t             item,
  input  logic [CALL_W-1:0] my_callsign,
  input  logic              digi_mode,
  output result_t           result
);

  frame_state_t st_r, st_nxt;

  // Byte i of our own address, byte 0 in the top bits
  function automatic logic [7:0] own_byte(input logic [CALL_W-1:0] call,
                                          input logic [2:0] idx);
    logic [7:0] ob;
    case (idx)
      3'd0:    ob = call[55:48];
      3'd1:    ob = call[47:40];
      3'd2:    ob = call[39:32];
      3'd3:    ob = call[31:24];
      3'd4:    ob = call[23:16];
      3'd5:    ob = call[15:8];
      default: ob = call[7:0];
    endcase
    return ob;
  endfunction

  always_comb begin : parse
    frame_state_t s;
    logic [7:0]   b;
    logic [7:0]   ob;
    logic [7:0]   mb;
    logic         ok;
    logic         full;
    logic         ext;
    logic         rep;
    logic [3:0]   k;
    verdict_t     vd;
    logic [3:0]   hop;

    s    = st_r;
    b    = item.data;
    ob   = b;
    mb   = own_byte(my_callsign, st_r.byte_in_addr);
    ok   = 1'b0;
    full = 1'b0;
    ext  = |(b & EXT_BIT);
    rep  = |(b & REPEAT_BIT);
    k    = st_r.addr_num - 4'd1;
    vd   = VERDICT_FORWARD;
    hop  = 4'd0;

    if (!st_r.hdr_done && st_r.addr_num != ADDR_OVERLONG) begin
      if (st_r.byte_in_addr < SSID_POS) begin
        // callsign character, compared without the shift bit
        ok = ((b ^ mb) & CALL_MASK) == 8'd0;
        if (st_r.byte_in_addr == 3'd0 && (b == 8'd0 || mb == 8'd0)) begin
          ok = 1'b0;
        end
        if (!ok) begin
          s.run_match = 1'b0;
        end
        s.byte_in_addr = st_r.byte_in_addr + 3'd1;
      end else begin
        // SSID byte closes one address
        full = st_r.run_match &&
               (((b ^ own_byte(my_callsign, SSID_POS)) & SSID_MASK) == 8'd0);
        if (st_r.addr_num == 4'd0) begin
          s.open_is_me = full;
        end else if (st_r.addr_num == 4'd1) begin
          if (ext) begin
            s.hdr_done  = 1'b1;
            s.hop_index = 4'd0;
          end
        end else begin
          if (st_r.hop_after) begin
            if (!rep) begin
              s.hdr_done  = 1'b1;
              s.hop_index = k;
            end else if (ext) begin
              s.hdr_done  = 1'b1;
              s.hop_index = 4'd0;
            end
          end else if (!rep) begin
            s.open_found = 1'b1;
            s.open_is_me = full;
            if (digi_mode) begin
              if (full) begin
                ob          = b | REPEAT_BIT;
                s.hop_after = 1'b1;
                if (ext) begin
                  s.hdr_done  = 1'b1;
                  s.hop_index = 4'd0;
                end
              end else begin
                s.hdr_done  = 1'b1;
                s.hop_index = 4'd0;
              end
            end else begin
              s.hdr_done  = 1'b1;
              s.hop_index = k;
            end
          end else if (ext) begin
            s.hdr_done  = 1'b1;
            s.hop_index = 4'd0;
          end
        end
        s.run_match    = 1'b1;
        s.byte_in_addr = 3'd0;
        if (st_r.addr_num >= 4'd2 && !s.hdr_done && k >= MAX_DIGIS) begin
          s.addr_num = ADDR_OVERLONG;
        end else begin
          s.addr_num = st_r.addr_num + 4'd1;
        end
      end
    end

    if (st_r.byte_pos < POS_SAT) begin
      s.byte_pos = st_r.byte_pos + 7'd1;
    end

    if (item.last) begin
      if (s.byte_pos < MIN_FRAME_LEN) begin
        vd = VERDICT_SHORT;
      end else if (!s.hdr_done) begin
        vd = VERDICT_UNTERMINATED;
      end else if (digi_mode) begin
        if (s.open_found) begin
          vd = s.open_is_me ? VERDICT_FORWARD : VERDICT_NOT_FOR_ME;
        end else begin
          vd = s.open_is_me ? VERDICT_DESTINATION : VERDICT_NOT_FOR_ME;
        end
      end else begin
        vd = VERDICT_FORWARD;
      end
      if (vd == VERDICT_FORWARD) begin
        hop = s.hop_index;
      end
      s = FRAME_CLEAR;
    end

    st_nxt          = s;
    result.data     = ob;
    result.last     = item.last;
    result.verdict  = vd;
    result.next_hop = hop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FRAME_CLEAR;
    end else if (ctl.advance) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: design/ax25dp_out_reg.sv
// ----------------------------------------------------------------------------
// ax25dp_out_reg
// Result register: holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module ax25dp_out_reg
  import ax25dp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  result_t   res_in,
  output logic      valid,
  output result_t   res_out
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign valid_nxt = ctl.advance | (valid_r & ~ctl.out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// File: design/ax25dp_checker.sv
// ----------------------------------------------------------------------------
// ax25dp_checker
// Port-level checks for the digipeater header processor, bound to the top.
// ----------------------------------------------------------------------------
module ax25dp_checker
  import ax25dp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast))
    else $error("result changed while stalled");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // verdict and hop only on the final byte
  a_mid_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[14:8] == 7'd0)
    else $error("verdict or hop set mid-frame");

  // a rejected frame carries no next hop
  a_hop_on_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] != VERDICT_FORWARD |-> out_tdata[14:11] == 4'd0)
    else $error("next hop on a rejected frame");

  // spare bit stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15] == 1'b0)
    else $error("pad bit set");

endmodule

bind ax25_digipeater_header_processor ax25dp_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
